[hdl/tcsec_pkg.sv]
package tcsec_pkg;

  // Default number of coordinates per point.
  localparam int unsigned DIMENSIONS_DEF = 4;

  // Widths of the fixed fields.
  localparam int unsigned COORD_W = 16;
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned OP_W = 2;
  localparam int unsigned MAX_DIMS = 4;

  // Datapath widths.
  localparam int unsigned SCL_W = 25;   // scaled distance, clamped to 2^24
  localparam int unsigned SQ_W = 49;    // square of one scaled distance
  localparam int unsigned SUM_W = 51;   // sum of up to four squares
  localparam int unsigned D2_W = 35;    // sum >> 16
  localparam int unsigned EXP_W = 33;   // Q1.32 exponential
  localparam int unsigned EXP_DEPTH = 513;
  localparam int unsigned EXP_AW = 10;

  // Opcodes.
  typedef enum logic [OP_W-1:0] {
    OP_VALUE  = 2'd0,
    OP_DLEN   = 2'd1,
    OP_DSIG   = 2'd2,
    OP_DANGLE = 2'd3
  } op_t;

  // Register indexes (paddr[3:2]).
  typedef enum logic [1:0] {
    REG_ILS   = 2'd0,
    REG_SVAR  = 2'd1,
    REG_CORR  = 2'd2,
    REG_SLOPE = 2'd3
  } reg_idx_t;

  localparam logic [15:0] ILS_RST = 16'd256;
  localparam logic [31:0] SVAR_RST = 32'd65536;
  localparam logic signed [15:0] CORR_RST = 16'sd16384;
  localparam logic signed [15:0] SLOPE_RST = 16'sd0;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_DEPTH-1];

  // Table of exp(-i/16) in Q1.32, each entry the rounded product of the last.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t tab;
    logic [65:0] prod;
    tab[0] = 33'h1_0000_0000;
    for (int i = 0; i < EXP_DEPTH - 1; i++) begin
      prod = 66'(tab[i]) * 66'd4034748382 + 66'h8000_0000;
      tab[i+1] = prod[64:32];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

[hdl/two_channel_se_covariance.sv]
// Two-channel squared-exponential covariance kernel.
// The in_ stream carries one point pair per beat: eight Q8.8 coordinates in
// tdata and the opcode plus both channel labels in tuser. The out_ stream
// returns one beat per input beat: the Q16.16 kernel entry or derivative in
// tdata and the saturation flag in tuser.
// The pipeline has eleven register stages. One beat is accepted every cycle
// while the output is not stalled; the rate is set by the single pipeline, in
// which every multiplier and the exponential table read have a stage of their
// own.
// When the receiver holds out_tready low with a result waiting, the whole
// pipeline freezes and in_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the registers with their defaults:
// inverse length scale 1.0, signal variance 1.0, correlation 1.0, slope 0.
// The APB port writes register i at byte address 4*i and reads it back;
// registers should be written only while the pipeline is empty.
module two_channel_se_covariance #(
  parameter int unsigned DIMENSIONS = tcsec_pkg::DIMENSIONS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // first_coord_0..3, then second_coord_0..3, 16 bits each from bit 0
  input  logic [127:0] in_tdata,
  // opcode [1:0], first_channel [9:2], second_channel [17:10]
  input  logic [17:0]  in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // kernel_value [31:0]
  output logic [31:0]  out_tdata,
  // saturated [0]
  output logic [0:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int unsigned NSTG = 11;

  // Configuration registers.
  logic [15:0]        ils_r;
  logic [31:0]        svar_r;
  logic signed [15:0] corr_r;
  logic signed [15:0] slope_r;
  logic               cfg_wr;
  tcsec_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx = tcsec_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ils_r <= tcsec_pkg::ILS_RST;
      svar_r <= tcsec_pkg::SVAR_RST;
      corr_r <= tcsec_pkg::CORR_RST;
      slope_r <= tcsec_pkg::SLOPE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tcsec_pkg::REG_ILS:   ils_r <= cfg_pwdata[15:0];
        tcsec_pkg::REG_SVAR:  svar_r <= cfg_pwdata;
        tcsec_pkg::REG_CORR:  corr_r <= cfg_pwdata[15:0];
        tcsec_pkg::REG_SLOPE: slope_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (cfg_idx)
      tcsec_pkg::REG_ILS:   cfg_prdata = {16'd0, ils_r};
      tcsec_pkg::REG_SVAR:  cfg_prdata = svar_r;
      tcsec_pkg::REG_CORR:  cfg_prdata = {16'd0, corr_r};
      tcsec_pkg::REG_SLOPE: cfg_prdata = {16'd0, slope_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // Pipeline advance: all stages move together unless the result is held.
  logic            en;
  logic [NSTG-1:0] vld_r;

  assign en = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // Side-band fields carried down the pipeline.
  tcsec_pkg::op_t op_r [1:8];
  logic           same_r [1:8];

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[1] <= tcsec_pkg::op_t'(in_tuser[1:0]);
      same_r[1] <= (in_tuser[9:2] == in_tuser[17:10]);
      for (int i = 2; i <= 8; i++) begin
        op_r[i] <= op_r[i-1];
        same_r[i] <= same_r[i-1];
      end
    end
  end

  // Stages 1 to 3: per-coordinate distance, scaling with clamp, square.
  logic [15:0]                  ad1_r [DIMENSIONS];
  logic [tcsec_pkg::SCL_W-1:0]  s2_r [DIMENSIONS];
  logic [tcsec_pkg::SQ_W-1:0]   sq3_r [DIMENSIONS];

  for (genvar k = 0; k < DIMENSIONS; k++) begin : g_lane
    logic signed [16:0] diff;
    logic [31:0]        scaled;

    assign diff = 17'($signed(in_tdata[16*k +: 16])) -
                  17'($signed(in_tdata[64 + 16*k +: 16]));
    assign scaled = {16'd0, ad1_r[k]} * {16'd0, ils_r};

    always_ff @(posedge clk) begin
      if (en) begin
        ad1_r[k] <= diff[16] ? 16'(-diff) : diff[15:0];
        s2_r[k] <= (scaled > 32'h0100_0000) ? 25'h100_0000 : scaled[24:0];
        sq3_r[k] <= 49'(s2_r[k]) * 49'(s2_r[k]);
      end
    end
  end

  // Stage 4: sum of squares, kept as d2 in Q19.16.
  logic [tcsec_pkg::SUM_W-1:0] sum;
  logic [tcsec_pkg::D2_W-1:0]  d2_4_r;

  always_comb begin
    sum = '0;
    for (int k = 0; k < DIMENSIONS; k++) sum = sum + tcsec_pkg::SUM_W'(sq3_r[k]);
  end

  always_ff @(posedge clk) begin
    if (en) d2_4_r <= sum[tcsec_pkg::SUM_W-1:16];
  end

  // Stage 5: exponential table read at the segment and the next one.
  logic [tcsec_pkg::EXP_AW-1:0] idx4;
  logic [tcsec_pkg::EXP_W-1:0]  lo5_r, hi5_r;
  logic [11:0]                  fr5_r;
  logic                         far5_r;
  logic [21:0]                  d2_r [5:8];

  assign idx4 = {1'b0, d2_4_r[21:13]};

  always_ff @(posedge clk) begin
    if (en) begin
      lo5_r <= tcsec_pkg::EXP_TAB[idx4];
      hi5_r <= tcsec_pkg::EXP_TAB[idx4 + 10'd1];
      fr5_r <= d2_4_r[12:1];
      far5_r <= |d2_4_r[tcsec_pkg::D2_W-1:22];
      d2_r[5] <= d2_4_r[21:0];
      for (int i = 6; i <= 8; i++) d2_r[i] <= d2_r[i-1];
    end
  end

  // Stage 6: slope times fraction.
  logic [tcsec_pkg::EXP_W-1:0] lo6_r;
  logic [44:0]                 dp6_r;
  logic                        far6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lo6_r <= lo5_r;
      dp6_r <= 45'(lo5_r - hi5_r) * 45'(fr5_r);
      far6_r <= far5_r;
    end
  end

  // Stage 7: interpolated exponential, zero for far points.
  logic [tcsec_pkg::EXP_W-1:0] e7_r;

  always_ff @(posedge clk) begin
    if (en) e7_r <= far6_r ? '0 : lo6_r - dp6_r[44:12];
  end

  // Stage 8: scale by the signal variance.
  logic [64:0] kv_full;
  logic [31:0] kv8_r;

  assign kv_full = 65'(svar_r) * 65'(e7_r);

  always_ff @(posedge clk) begin
    if (en) kv8_r <= kv_full[63:32];
  end

  // Stage 9: magnitude by opcode and choice of channel factor.
  logic [53:0]        kd;
  logic [37:0]        mag9_r;
  logic signed [15:0] f9_r;

  assign kd = 54'(kv8_r) * 54'(d2_r[8]);

  always_ff @(posedge clk) begin
    if (en) begin
      case (op_r[8])
        tcsec_pkg::OP_DLEN: mag9_r <= kd[53:16];
        tcsec_pkg::OP_DSIG: mag9_r <= {5'd0, kv8_r, 1'b0};
        default:            mag9_r <= {6'd0, kv8_r};
      endcase
      if (op_r[8] == tcsec_pkg::OP_DANGLE) f9_r <= same_r[8] ? 16'sd0 : slope_r;
      else f9_r <= same_r[8] ? tcsec_pkg::ONE_Q14 : corr_r;
    end
  end

  // Stage 10: apply the factor magnitude, truncating toward zero.
  logic [15:0] fmag;
  logic [53:0] fp;
  logic [39:0] mag10_r;
  logic        neg10_r;

  assign fmag = f9_r[15] ? 16'(-f9_r) : f9_r;
  assign fp = 54'(mag9_r) * 54'(fmag);

  always_ff @(posedge clk) begin
    if (en) begin
      mag10_r <= fp[53:14];
      neg10_r <= f9_r[15];
    end
  end

  // Stage 11: sign, saturation and the output register.
  logic        neg;
  logic [39:0] lim;
  logic [39:0] magc;
  logic [31:0] kval_r;
  logic        sat_r;

  assign neg = neg10_r && (mag10_r != '0);
  assign lim = neg ? 40'h00_8000_0000 : 40'h00_7FFF_FFFF;
  assign magc = (mag10_r > lim) ? lim : mag10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kval_r <= neg ? 32'(-magc) : magc[31:0];
      sat_r <= (mag10_r > lim);
    end
  end

  assign out_tdata = kval_r;
  assign out_tuser = sat_r;

endmodule
